/* sv/gctw_pkg.sv */
// Shared types and constants for the card-table write barrier.
package gctw_pkg;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int BASE_W   = 48;
    localparam int HBYTES_W = 22;
    localparam int CCOUNT_W = 13;
    localparam int SIZE_W   = 22;
    localparam int GEN_W    = 2;
    localparam int QIDX_W   = 12;
    localparam int CNT_W    = 13;

    // APB register map: 64-bit registers at 8-byte strides
    localparam int PDATA_W  = 64;
    localparam int PADDR_W  = 5;

    localparam logic [1:0] REG_HEAP_BASE  = 2'd0;
    localparam logic [1:0] REG_HEAP_BYTES = 2'd1;
    localparam logic [1:0] REG_CARD_COUNT = 2'd2;

    // Generation codes
    localparam logic [GEN_W-1:0] GEN_YOUNG = 2'd0;
    localparam logic [GEN_W-1:0] GEN_OLD   = 2'd1;
    localparam logic [GEN_W-1:0] GEN_PERM  = 2'd2;
    localparam logic [GEN_W-1:0] GEN_BAD   = 2'd3;

    // Command queue depth
    localparam int Q_DEPTH = 2;

    typedef enum logic [1:0] {
        K_STORE   = 2'd0,
        K_QUERY   = 2'd1,
        K_CLEAR   = 2'd2,
        K_UNKNOWN = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ARG    = 2'd1,
        ST_BOUNDS = 2'd2,
        ST_GEN    = 2'd3
    } status_t;

    // Classified request handed from front to back
    typedef struct packed {
        kind_t   kind;
        logic    cfg_arg;     // config unusable: invalid argument
        logic    cfg_bounds;  // card_count does not cover heap
        status_t pre_status;  // store status once config passes
        logic    walk;        // store needs cards marked
        logic    qidx_ok;     // query index is in range
    } cmd_flags_t;

    typedef enum logic [2:0] {
        B_INIT,
        B_IDLE,
        B_QRD,
        B_RD,
        B_WR,
        B_CLR
    } back_state_t;

endpackage

/* sv/gc_card_table_write_barrier.sv */
// Top level of the card-table write barrier: config registers, front, queue, back.
//
// Usage:
//  - Request channel (s_*): op 0 records a store (address, store_bytes, owner and
//    value generation), op 1 queries card card_index, op 2 clears all cards.
//  - Result channel (m_*): exactly one result per request, in request order:
//    status, card_is_dirty (query only) and the dirty card total after it.
//  - APB port: heap_base at 0x00, heap_bytes at 0x08, card_count at 0x10, 64-bit
//    data; pready is tied high. Write only while no request is in flight.
//  - Path: one front stage, then the queue head reaches the back end. Requests
//    with no memory work pass the front stage, the queue and the result register;
//    a query of a valid card adds a card RAM read. A store walks its cards in turn,
//    each card a read then a conditional write on the single card RAM.
//    A clear sweeps all MAX_CARDS entries, one per cycle.
//  - Flow: set by the back end; a two-entry queue lets the front keep
//    accepting while the back walks cards or the result waits.
//  - Reset: synchronous, active low. Afterwards the card RAM is cleared one
//    entry per cycle over all MAX_CARDS entries (4096 by default); s_ready stays low
//    during that pass, config writes are taken as usual.
//  - A stalled receiver holds the result register; the back end stops popping
//    and the queue and front fill, then s_ready drops.
module gc_card_table_write_barrier #(
    parameter int CARD_SHIFT = 9,
    parameter int MAX_CARDS  = 4096,
    parameter int ADDR_BITS  = 48
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gctw_pkg::PADDR_W-1:0]   paddr,
    input  logic [gctw_pkg::PDATA_W-1:0]   pwdata,
    output logic [gctw_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    // Request channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [gctw_pkg::OP_W-1:0]      s_op,
    input  logic [gctw_pkg::BASE_W-1:0]    s_address,
    input  logic [gctw_pkg::SIZE_W-1:0]    s_store_bytes,
    input  logic [gctw_pkg::GEN_W-1:0]     s_owner_generation,
    input  logic [gctw_pkg::GEN_W-1:0]     s_value_generation,
    input  logic [gctw_pkg::QIDX_W-1:0]    s_card_index,
    // Result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_status,
    output logic                           m_card_is_dirty,
    output logic [gctw_pkg::CNT_W-1:0]     m_dirty_total
);

    localparam int CIDX_W = (MAX_CARDS > 1) ? $clog2(MAX_CARDS) : 1;
    localparam int QW     = $bits(gctw_pkg::cmd_flags_t) + 2 * CIDX_W;

    logic [gctw_pkg::BASE_W-1:0]   heap_base_reg;
    logic [gctw_pkg::HBYTES_W-1:0] heap_bytes_reg;
    logic [gctw_pkg::CCOUNT_W-1:0] card_count_reg;
    logic [1:0]                    reg_idx;
    logic                          cfg_write;

    logic                          init_busy;
    logic                          fq_push;
    logic                          fq_ready;
    gctw_pkg::cmd_flags_t          f_flags;
    logic [CIDX_W-1:0]             f_first;
    logic [CIDX_W-1:0]             f_last;
    logic [QW-1:0]                 q_out;
    logic                          q_valid;
    logic                          q_pop;
    gctw_pkg::cmd_flags_t          b_flags;
    logic [CIDX_W-1:0]             b_first;
    logic [CIDX_W-1:0]             b_last;

    // Configuration registers
    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg  <= '0;
            heap_bytes_reg <= '0;
            card_count_reg <= '0;
        end else if (cfg_write) begin
            unique case (reg_idx)
                gctw_pkg::REG_HEAP_BASE:  heap_base_reg  <= pwdata[gctw_pkg::BASE_W-1:0];
                gctw_pkg::REG_HEAP_BYTES: heap_bytes_reg <= pwdata[gctw_pkg::HBYTES_W-1:0];
                gctw_pkg::REG_CARD_COUNT: card_count_reg <= pwdata[gctw_pkg::CCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            gctw_pkg::REG_HEAP_BASE:  prdata = gctw_pkg::PDATA_W'(heap_base_reg);
            gctw_pkg::REG_HEAP_BYTES: prdata = gctw_pkg::PDATA_W'(heap_bytes_reg);
            gctw_pkg::REG_CARD_COUNT: prdata = gctw_pkg::PDATA_W'(card_count_reg);
            default:                  prdata = '0;
        endcase
    end

    // Front end: classify and range-check
    gctw_front #(
        .ADDR_BITS  (ADDR_BITS),
        .CARD_SHIFT (CARD_SHIFT),
        .MAX_CARDS  (MAX_CARDS),
        .CIDX_W     (CIDX_W)
    ) u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .hold               (init_busy),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_op               (s_op),
        .s_address          (s_address),
        .s_store_bytes      (s_store_bytes),
        .s_owner_generation (s_owner_generation),
        .s_value_generation (s_value_generation),
        .s_card_index       (s_card_index),
        .heap_base          (heap_base_reg),
        .heap_bytes         (heap_bytes_reg),
        .card_count         (card_count_reg),
        .q_ready            (fq_ready),
        .q_push             (fq_push),
        .q_flags            (f_flags),
        .q_first            (f_first),
        .q_last             (f_last)
    );

    // Request queue
    gctw_queue #(
        .W (QW)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (fq_push),
        .push_data  ({f_flags, f_first, f_last}),
        .push_ready (fq_ready),
        .pop        (q_pop),
        .pop_data   (q_out),
        .pop_valid  (q_valid)
    );

    assign {b_flags, b_first, b_last} = q_out;

    // Back end: card RAM, count and result register
    gctw_back #(
        .MAX_CARDS (MAX_CARDS),
        .CIDX_W    (CIDX_W)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_pop           (q_pop),
        .q_flags         (b_flags),
        .q_first         (b_first),
        .q_last          (b_last),
        .card_count      (card_count_reg),
        .busy            (init_busy),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_card_is_dirty (m_card_is_dirty),
        .m_dirty_total   (m_dirty_total)
    );

    // No request is taken during the post-reset clearing pass
    a_no_accept_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        init_busy |-> !s_ready)
        else $error("request accepted during RAM clearing pass");

    // The clearing pass only happens once per reset
    a_init_once: assert property (@(posedge aclk) disable iff (!aresetn)
        !init_busy |=> !init_busy)
        else $error("clearing pass restarted without reset");

    // The dirty total can never exceed the table size
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_dirty_total) <= 32'(MAX_CARDS)))
        else $error("dirty total beyond card table size");

    // A dirty answer only comes with an ok status
    a_dirty_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_card_is_dirty) |-> (m_status == gctw_pkg::ST_OK))
        else $error("dirty flag on a failed request");

endmodule

/* sv/gctw_front.sv */
// Front end: accepts requests, range-checks stores and classifies them.
module gctw_front #(
    parameter int ADDR_BITS  = 48,
    parameter int CARD_SHIFT = 9,
    parameter int MAX_CARDS  = 4096,
    parameter int CIDX_W     = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          hold,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [gctw_pkg::OP_W-1:0]     s_op,
    input  logic [gctw_pkg::BASE_W-1:0]   s_address,
    input  logic [gctw_pkg::SIZE_W-1:0]   s_store_bytes,
    input  logic [gctw_pkg::GEN_W-1:0]    s_owner_generation,
    input  logic [gctw_pkg::GEN_W-1:0]    s_value_generation,
    input  logic [gctw_pkg::QIDX_W-1:0]   s_card_index,
    input  logic [gctw_pkg::BASE_W-1:0]   heap_base,
    input  logic [gctw_pkg::HBYTES_W-1:0] heap_bytes,
    input  logic [gctw_pkg::CCOUNT_W-1:0] card_count,
    input  logic                          q_ready,
    output logic                          q_push,
    output gctw_pkg::cmd_flags_t          q_flags,
    output logic [CIDX_W-1:0]             q_first,
    output logic [CIDX_W-1:0]             q_last
);

    localparam int AW     = ADDR_BITS;
    localparam int WIDE_W = (ADDR_BITS > gctw_pkg::HBYTES_W) ? ADDR_BITS : gctw_pkg::HBYTES_W;
    localparam int SUM_W  = WIDE_W + 1;
    localparam int HB1_W  = gctw_pkg::HBYTES_W + 1;
    localparam logic [HB1_W-1:0] CARD_MASK = HB1_W'((64'd1 << CARD_SHIFT) - 64'd1);

    // Stage 1 registers
    logic                          s1_valid_reg;
    gctw_pkg::kind_t               kind_reg;
    logic                          gen_bad_reg;
    logic                          size_zero_reg;
    logic                          mark_reg;
    logic                          addr_zero_reg;
    logic                          below_reg;
    logic                          wrap_reg;
    logic [AW-1:0]                 off_reg;
    logic [gctw_pkg::SIZE_W-1:0]   size_reg;
    logic [gctw_pkg::QIDX_W-1:0]   qidx_reg;

    logic                          take;
    gctw_pkg::kind_t               kind_next;
    logic [AW-1:0]                 addr_m;
    logic [AW-1:0]                 base_m;
    logic [SUM_W-1:0]              span_sum;

    // Stage 2 logic
    logic [gctw_pkg::HBYTES_W-1:0] off_lo;
    logic                          in_heap;
    logic [HB1_W-1:0]              end_off;
    logic                          end_ok;
    logic [gctw_pkg::HBYTES_W-1:0] first_off;
    logic [HB1_W-1:0]              last_off;
    logic                          span_bad;
    logic [HB1_W-1:0]              need_sum;
    logic [HB1_W-1:0]              need;

    assign s_ready = !hold && (!s1_valid_reg || q_ready);
    assign take    = s_valid && s_ready;
    assign q_push  = s1_valid_reg && q_ready;

    always_comb begin
        unique case (s_op)
            gctw_pkg::K_STORE: kind_next = gctw_pkg::K_STORE;
            gctw_pkg::K_QUERY: kind_next = gctw_pkg::K_QUERY;
            gctw_pkg::K_CLEAR: kind_next = gctw_pkg::K_CLEAR;
            default:           kind_next = gctw_pkg::K_UNKNOWN;
        endcase
    end

    assign addr_m   = AW'(s_address);
    assign base_m   = AW'(heap_base);
    assign span_sum = SUM_W'(addr_m) + SUM_W'(s_store_bytes);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (take) begin
            s1_valid_reg <= 1'b1;
        end else if (q_ready) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            kind_reg      <= kind_next;
            gen_bad_reg   <= (s_owner_generation == gctw_pkg::GEN_BAD) ||
                             (s_value_generation == gctw_pkg::GEN_BAD);
            size_zero_reg <= (s_store_bytes == '0);
            mark_reg      <= ((s_owner_generation == gctw_pkg::GEN_OLD) ||
                              (s_owner_generation == gctw_pkg::GEN_PERM)) &&
                             (s_value_generation == gctw_pkg::GEN_YOUNG);
            addr_zero_reg <= (addr_m == '0);
            below_reg     <= (addr_m < base_m);
            wrap_reg      <= |(span_sum >> AW);
            off_reg       <= addr_m - base_m;
            size_reg      <= s_store_bytes;
            qidx_reg      <= s_card_index;
        end
    end

    // Span against heap and card range
    assign off_lo    = gctw_pkg::HBYTES_W'(off_reg);
    assign in_heap   = WIDE_W'(off_reg) < WIDE_W'(heap_bytes);
    assign end_off   = HB1_W'(off_lo) + HB1_W'(size_reg) - HB1_W'(1);
    assign end_ok    = end_off < HB1_W'(heap_bytes);
    assign first_off = off_lo >> CARD_SHIFT;
    assign last_off  = end_off >> CARD_SHIFT;

    assign span_bad = addr_zero_reg || below_reg || !in_heap || wrap_reg || !end_ok ||
                      (HB1_W'(first_off) > last_off) ||
                      (last_off >= HB1_W'(card_count)) ||
                      (32'(last_off) >= 32'(MAX_CARDS));

    assign need_sum = HB1_W'(heap_bytes) + CARD_MASK;
    assign need     = need_sum >> CARD_SHIFT;

    always_comb begin
        q_flags.kind       = kind_reg;
        q_flags.cfg_arg    = (heap_base == '0) || (heap_bytes == '0) || (card_count == '0) ||
                             (32'(card_count) > 32'(MAX_CARDS));
        q_flags.cfg_bounds = HB1_W'(card_count) < need;
        q_flags.walk       = 1'b0;
        q_flags.qidx_ok    = (32'(qidx_reg) < 32'(card_count)) &&
                             (32'(qidx_reg) < 32'(MAX_CARDS));
        if (gen_bad_reg) begin
            q_flags.pre_status = gctw_pkg::ST_GEN;
        end else if (size_zero_reg) begin
            q_flags.pre_status = gctw_pkg::ST_OK;
        end else if (span_bad) begin
            q_flags.pre_status = gctw_pkg::ST_BOUNDS;
        end else begin
            q_flags.pre_status = gctw_pkg::ST_OK;
            q_flags.walk       = mark_reg;
        end
    end

    // Query reuses the first-card slot for its index
    assign q_first = (kind_reg == gctw_pkg::K_QUERY) ? CIDX_W'(qidx_reg) : CIDX_W'(first_off);
    assign q_last  = CIDX_W'(last_off);

endmodule

/* sv/gctw_queue.sv */
// Small FIFO between front and back ends.
module gctw_queue #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         push_ready,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         pop_valid
);

    localparam int PTR_W = (gctw_pkg::Q_DEPTH > 1) ? $clog2(gctw_pkg::Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(gctw_pkg::Q_DEPTH + 1);

    logic [W-1:0]     entry_reg [gctw_pkg::Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign push_ready = (cnt_reg != CNT_W'(gctw_pkg::Q_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(gctw_pkg::Q_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(gctw_pkg::Q_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* sv/gctw_back.sv */
// Back end: card memory, dirty count, card walker and result register.
module gctw_back #(
    parameter int MAX_CARDS = 4096,
    parameter int CIDX_W    = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  gctw_pkg::cmd_flags_t          q_flags,
    input  logic [CIDX_W-1:0]             q_first,
    input  logic [CIDX_W-1:0]             q_last,
    input  logic [gctw_pkg::CCOUNT_W-1:0] card_count,
    output logic                          busy,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic                          m_card_is_dirty,
    output logic [gctw_pkg::CNT_W-1:0]    m_dirty_total
);

    gctw_pkg::back_state_t       state_reg, state_next;
    logic [CIDX_W-1:0]           cur_reg, cur_next;
    logic [CIDX_W-1:0]           last_reg, last_next;
    logic [gctw_pkg::CNT_W-1:0]  count_reg, count_next;

    logic                        mem [MAX_CARDS];
    logic                        rd_data_reg;
    logic [CIDX_W-1:0]           raddr;
    logic                        mem_we;
    logic [CIDX_W-1:0]           waddr;
    logic                        wdata;

    logic                        out_valid_reg;
    gctw_pkg::status_t           out_status_reg;
    logic                        out_dirty_reg;
    logic [gctw_pkg::CNT_W-1:0]  out_total_reg;
    logic                        out_load;
    gctw_pkg::status_t           out_status;
    logic                        out_dirty;
    logic [gctw_pkg::CNT_W-1:0]  out_total;

    // Decode of the request at the queue head
    logic                        can_pop;
    gctw_pkg::status_t           cfg_st;
    gctw_pkg::status_t           imm_st;
    logic                        go_walk;
    logic                        go_query;
    logic                        go_clear;
    logic                        last_card;
    logic                        sweep_end;

    assign can_pop   = q_valid && (!out_valid_reg || m_ready);
    assign last_card = (cur_reg == last_reg);
    assign sweep_end = (cur_reg == CIDX_W'(MAX_CARDS - 1));
    assign busy      = (state_reg == gctw_pkg::B_INIT);

    always_comb begin
        if (q_flags.cfg_arg) begin
            cfg_st = gctw_pkg::ST_ARG;
        end else if (q_flags.cfg_bounds || (count_reg > card_count)) begin
            cfg_st = gctw_pkg::ST_BOUNDS;
        end else begin
            cfg_st = gctw_pkg::ST_OK;
        end
        go_walk  = 1'b0;
        go_query = 1'b0;
        go_clear = 1'b0;
        imm_st   = gctw_pkg::ST_OK;
        unique case (q_flags.kind)
            gctw_pkg::K_STORE: begin
                imm_st  = (cfg_st != gctw_pkg::ST_OK) ? cfg_st : q_flags.pre_status;
                go_walk = (cfg_st == gctw_pkg::ST_OK) && q_flags.walk;
            end
            gctw_pkg::K_QUERY: begin
                go_query = q_flags.qidx_ok;
            end
            gctw_pkg::K_CLEAR: begin
                imm_st   = cfg_st;
                go_clear = (cfg_st == gctw_pkg::ST_OK);
            end
            default: begin
                imm_st = gctw_pkg::ST_ARG;
            end
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gctw_pkg::B_INIT: if (sweep_end) state_next = gctw_pkg::B_IDLE;
            gctw_pkg::B_IDLE: begin
                if (can_pop) begin
                    if (go_walk) begin
                        state_next = gctw_pkg::B_RD;
                    end else if (go_query) begin
                        state_next = gctw_pkg::B_QRD;
                    end else if (go_clear) begin
                        state_next = gctw_pkg::B_CLR;
                    end
                end
            end
            gctw_pkg::B_QRD: state_next = gctw_pkg::B_IDLE;
            gctw_pkg::B_RD:  state_next = gctw_pkg::B_WR;
            gctw_pkg::B_WR:  state_next = last_card ? gctw_pkg::B_IDLE : gctw_pkg::B_RD;
            gctw_pkg::B_CLR: if (sweep_end) state_next = gctw_pkg::B_IDLE;
            default:         state_next = gctw_pkg::B_INIT;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        q_pop      = 1'b0;
        raddr      = cur_reg;
        mem_we     = 1'b0;
        waddr      = cur_reg;
        wdata      = 1'b0;
        cur_next   = cur_reg;
        last_next  = last_reg;
        count_next = count_reg;
        out_load   = 1'b0;
        out_status = gctw_pkg::ST_OK;
        out_dirty  = 1'b0;
        out_total  = count_reg;
        unique case (state_reg)
            gctw_pkg::B_INIT: begin
                mem_we   = 1'b1;
                cur_next = cur_reg + 1'b1;
            end
            gctw_pkg::B_IDLE: begin
                raddr = q_first;
                if (can_pop) begin
                    q_pop     = 1'b1;
                    cur_next  = go_clear ? '0 : q_first;
                    last_next = q_last;
                    if (!go_walk && !go_query && !go_clear) begin
                        out_load   = 1'b1;
                        out_status = imm_st;
                    end
                end
            end
            gctw_pkg::B_QRD: begin
                out_load  = 1'b1;
                out_dirty = rd_data_reg;
            end
            gctw_pkg::B_RD: begin
                raddr = cur_reg;
            end
            gctw_pkg::B_WR: begin
                if (!rd_data_reg) begin
                    mem_we     = 1'b1;
                    wdata      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                cur_next = cur_reg + 1'b1;
                if (last_card) begin
                    out_load  = 1'b1;
                    out_total = count_next;
                end
            end
            gctw_pkg::B_CLR: begin
                mem_we   = 1'b1;
                cur_next = cur_reg + 1'b1;
                if (sweep_end) begin
                    count_next = '0;
                    out_load   = 1'b1;
                    out_total  = '0;
                end
            end
            default: begin
                cur_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gctw_pkg::B_INIT;
            cur_reg   <= '0;
            last_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            last_reg  <= last_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_status_reg <= out_status;
            out_dirty_reg  <= out_dirty;
            out_total_reg  <= out_total;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_status_reg;
    assign m_card_is_dirty = out_dirty_reg;
    assign m_dirty_total   = out_total_reg;

endmodule
